>>> src/bogadd_pkg.sv
// shared types and constants for the bilinear offset grid adder
`timescale 1ns / 1ps

package bogadd_pkg;

   localparam int DEF_MAX_X_NODES = 16;
   localparam int DEF_MAX_Y_NODES = 16;
   localparam int GRID_DEPTH      = 256;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef enum logic [1:0] {
      ACT_LOAD_X    = 2'd0,
      ACT_LOAD_Y    = 2'd1,
      ACT_LOAD_GRID = 2'd2,
      ACT_PIXEL     = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      CSR_X_COUNT = 4'd0,
      CSR_Y_COUNT = 4'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD_FIRST,
      OP_CLIP_LO,
      OP_RD_LAST,
      OP_CLIP_HI,
      OP_RD_SCAN,
      OP_TEST,
      OP_CLAMP,
      OP_RD_LO,
      OP_GET_LO,
      OP_RD_HI,
      OP_GET_HI,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SAVE_W,
      OP_BASE,
      OP_GRD,
      OP_MUL,
      OP_ACC,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic req_pixel;
      logic scan_end;
      logic div_done;
      logic axis_y;
      logic corners_done;
      logic out_busy;
   } status_type;

endpackage

>>> src/bogadd_if.sv
// item channel interfaces for the bilinear offset grid adder
`timescale 1ns / 1ps

interface bogadd_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic        [7:0]  table_index;
   logic signed [31:0] data_word;
   logic        [15:0] row_position;
   logic        [15:0] column;
   modport source (output valid, action, table_index, data_word, row_position, column,
                   input ready);
   modport sink (input valid, action, table_index, data_word, row_position, column,
                 output ready);
endinterface

interface bogadd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] corrected_value;
   logic               saturated;
   modport source (output valid, corrected_value, saturated, input ready);
   modport sink (input valid, corrected_value, saturated, output ready);
endinterface

interface bogadd_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [4:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/bogadd_dp.sv
// datapath: tables, node search, weight divider, blend and saturation
`timescale 1ns / 1ps

module bogadd_dp import bogadd_pkg::*; #(
   parameter int MAX_X_NODES = DEF_MAX_X_NODES,
   parameter int MAX_Y_NODES = DEF_MAX_Y_NODES
) (
   input  logic               clock,
   input  logic               reset,
   input  op_type             cmd,
   output status_type         status,
   input  logic        [1:0]  req_action,
   input  logic        [7:0]  req_table_index,
   input  logic signed [31:0] req_data_word,
   input  logic        [15:0] req_row_position,
   input  logic        [15:0] req_column,
   input  logic               csr_valid,
   input  logic        [3:0]  csr_index,
   input  logic        [4:0]  csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_corrected_value,
   output logic               rsp_saturated
);

   localparam int MAXN = (MAX_X_NODES > MAX_Y_NODES) ? MAX_X_NODES : MAX_Y_NODES;
   localparam int CW   = $clog2(MAXN + 1);
   localparam int XAW  = $clog2(MAX_X_NODES);
   localparam int YAW  = $clog2(MAX_Y_NODES);
   localparam int GAW0 = $clog2(MAX_X_NODES * MAX_Y_NODES) + 1;
   localparam int GAW  = (GAW0 > 9) ? GAW0 : 9;
   localparam int GDW  = $clog2(GRID_DEPTH);

   logic [31:0] xmem [MAX_X_NODES];
   logic [31:0] ymem [MAX_Y_NODES];
   logic [31:0] gmem [GRID_DEPTH];

   logic [4:0]         xcnt_ff, ycnt_ff;
   logic [CW-1:0]      nx, ny, n, na;
   logic [15:0]        coord;
   logic [31:0]        node_rd;
   logic [31:0]        rdx_ff, rdy_ff, grd_ff;
   logic               oob_ff;
   logic signed [31:0] word_ff;
   logic [15:0]        row_ff, col_ff;
   logic               axis_ff, found_ff;
   logic [31:0]        pos_ff, lo_ff, hi_ff, rem_ff, den_ff;
   logic [CW-1:0]      scan_ff, xl_ff, yl_ff;
   logic [16:0]        quo_ff, wx_ff, wy_ff, wxi, wyj;
   logic [4:0]         cnt_ff;
   logic [32:0]        sh;
   logic [GAW-1:0]     gbase_ff, ga;
   logic [2:0]         corner_ff;
   logic [32:0]        wp_prod;
   logic [32:0]        wp_ff;
   logic signed [31:0] gsel;
   logic signed [65:0] prod_ff, acc_ff, rnd;
   logic signed [33:0] offset;
   logic signed [34:0] sum;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_sat_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         xcnt_ff <= 5'd2;
         ycnt_ff <= 5'd2;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_X_COUNT: xcnt_ff <= csr_data;
            CSR_Y_COUNT: ycnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign nx = (xcnt_ff < 5'd2) ? CW'(2) :
               (int'(xcnt_ff) > MAX_X_NODES) ? CW'(MAX_X_NODES) : CW'(xcnt_ff);
   assign ny = (ycnt_ff < 5'd2) ? CW'(2) :
               (int'(ycnt_ff) > MAX_Y_NODES) ? CW'(MAX_Y_NODES) : CW'(ycnt_ff);
   assign n     = axis_ff ? ny : nx;
   assign coord = axis_ff ? row_ff : col_ff;

   always_comb begin
      case (cmd)
         OP_RD_LAST:            na = n - CW'(1);
         OP_RD_SCAN, OP_RD_HI:  na = scan_ff;
         OP_RD_LO:              na = scan_ff - CW'(1);
         default:               na = '0;
      endcase
   end

   // node and grid memories
   always_ff @(posedge clock) begin
      if (cmd == OP_ACCEPT && req_action == ACT_LOAD_X &&
          int'(req_table_index) < MAX_X_NODES) begin
         xmem[req_table_index[XAW-1:0]] <= req_data_word;
      end
      if (cmd == OP_ACCEPT && req_action == ACT_LOAD_Y &&
          int'(req_table_index) < MAX_Y_NODES) begin
         ymem[req_table_index[YAW-1:0]] <= req_data_word;
      end
      if (cmd == OP_ACCEPT && req_action == ACT_LOAD_GRID) begin
         gmem[req_table_index[GDW-1:0]] <= req_data_word;
      end
   end

   always_ff @(posedge clock) begin
      rdx_ff <= xmem[na[XAW-1:0]];
      rdy_ff <= ymem[na[YAW-1:0]];
      grd_ff <= gmem[ga[GDW-1:0]];
      oob_ff <= ga >= GAW'(GRID_DEPTH);
   end

   assign node_rd = axis_ff ? rdy_ff : rdx_ff;

   assign ga  = gbase_ff + GAW'(corner_ff[0]) + (corner_ff[1] ? GAW'(nx) : '0);
   assign wxi = corner_ff[0] ? wx_ff : ONE_Q16 - wx_ff;
   assign wyj = corner_ff[1] ? wy_ff : ONE_Q16 - wy_ff;
   assign wp_prod = 33'(wxi) * 33'(wyj);
   assign gsel    = oob_ff ? 32'sd0 : $signed(grd_ff);
   assign sh      = {rem_ff, 1'b0};

   assign rnd    = acc_ff + 66'sd2147483648;
   assign offset = rnd[65:32];
   assign sum    = $signed({{3{word_ff[31]}}, word_ff}) + $signed({offset[33], offset});

   // pixel datapath
   always_ff @(posedge clock) begin
      case (cmd)
         OP_ACCEPT: begin
            word_ff <= req_data_word;
            row_ff  <= req_row_position;
            col_ff  <= req_column;
         end
         OP_RD_FIRST: pos_ff <= {8'd0, coord, 8'd0};
         OP_CLIP_LO: begin
            if (pos_ff < node_rd) begin
               pos_ff <= node_rd;
            end
         end
         OP_CLIP_HI: begin
            if (pos_ff > node_rd) begin
               pos_ff <= node_rd;
            end
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end
         OP_TEST: begin
            if (node_rd > pos_ff) begin
               found_ff <= 1'b1;
            end else begin
               scan_ff <= scan_ff + CW'(1);
            end
         end
         OP_CLAMP: begin
            if (scan_ff == '0) begin
               scan_ff <= CW'(1);
            end else if (scan_ff > n - CW'(1)) begin
               scan_ff <= n - CW'(1);
            end
         end
         OP_GET_LO: lo_ff <= node_rd;
         OP_GET_HI: hi_ff <= node_rd;
         OP_DIV_INIT: begin
            quo_ff <= '0;
            cnt_ff <= '0;
            if (hi_ff <= lo_ff || pos_ff < lo_ff) begin
               quo_ff <= '0;
            end else if (pos_ff - lo_ff >= hi_ff - lo_ff) begin
               quo_ff <= ONE_Q16;
            end else begin
               rem_ff <= pos_ff - lo_ff;
               den_ff <= hi_ff - lo_ff;
               cnt_ff <= 5'd16;
            end
         end
         OP_DIV_STEP: begin
            if (sh >= {1'b0, den_ff}) begin
               rem_ff <= 32'(sh - {1'b0, den_ff});
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= sh[31:0];
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
         end
         OP_SAVE_W: begin
            if (axis_ff) begin
               wy_ff <= quo_ff;
               yl_ff <= scan_ff - CW'(1);
            end else begin
               wx_ff <= quo_ff;
               xl_ff <= scan_ff - CW'(1);
            end
         end
         OP_BASE: begin
            gbase_ff <= GAW'(yl_ff) * GAW'(nx) + GAW'(xl_ff);
            acc_ff   <= '0;
         end
         OP_GRD: wp_ff <= wp_prod;
         OP_MUL: prod_ff <= gsel * $signed({1'b0, wp_ff});
         OP_ACC: acc_ff <= acc_ff + prod_ff;
         OP_FINISH: begin
            if (!sum[34] && (|sum[33:31])) begin
               rsp_value_ff <= 32'sh7fffffff;
               rsp_sat_ff   <= 1'b1;
            end else if (sum[34] && !(&sum[33:31])) begin
               rsp_value_ff <= 32'sh80000000;
               rsp_sat_ff   <= 1'b1;
            end else begin
               rsp_value_ff <= sum[31:0];
               rsp_sat_ff   <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= 1'b0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == OP_ACCEPT) begin
            axis_ff <= 1'b0;
         end else if (cmd == OP_SAVE_W) begin
            axis_ff <= !axis_ff;
         end
         if (cmd == OP_BASE) begin
            corner_ff <= '0;
         end else if (cmd == OP_ACC) begin
            corner_ff <= corner_ff + 3'd1;
         end
         if (cmd == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.req_pixel    = req_action == ACT_PIXEL;
   assign status.scan_end     = found_ff || scan_ff == n;
   assign status.div_done     = cnt_ff == 5'd0;
   assign status.axis_y       = axis_ff;
   assign status.corners_done = corner_ff == 3'd4;
   assign status.out_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_value = rsp_value_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

>>> src/bogadd_ctrl.sv
// controller state machine sequencing the pixel datapath
`timescale 1ns / 1ps

module bogadd_ctrl import bogadd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output op_type     cmd
);

   typedef enum logic [19:0] {
      S_IDLE      = 20'h00001,
      S_RD_FIRST  = 20'h00002,
      S_CLIP_LO   = 20'h00004,
      S_RD_LAST   = 20'h00008,
      S_CLIP_HI   = 20'h00010,
      S_SCAN_RD   = 20'h00020,
      S_SCAN_TEST = 20'h00040,
      S_CLAMP     = 20'h00080,
      S_RD_LO     = 20'h00100,
      S_GET_LO    = 20'h00200,
      S_RD_HI     = 20'h00400,
      S_GET_HI    = 20'h00800,
      S_DIV_INIT  = 20'h01000,
      S_DIV_STEP  = 20'h02000,
      S_SAVE_W    = 20'h04000,
      S_BASE      = 20'h08000,
      S_GRD       = 20'h10000,
      S_MUL       = 20'h20000,
      S_ACC       = 20'h40000,
      S_FINISH    = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd = OP_ACCEPT;
               if (status.req_pixel) begin
                  state_in = S_RD_FIRST;
               end
            end
         end
         S_RD_FIRST: begin
            cmd      = OP_RD_FIRST;
            state_in = S_CLIP_LO;
         end
         S_CLIP_LO: begin
            cmd      = OP_CLIP_LO;
            state_in = S_RD_LAST;
         end
         S_RD_LAST: begin
            cmd      = OP_RD_LAST;
            state_in = S_CLIP_HI;
         end
         S_CLIP_HI: begin
            cmd      = OP_CLIP_HI;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = S_CLAMP;
            end else begin
               cmd      = OP_RD_SCAN;
               state_in = S_SCAN_TEST;
            end
         end
         S_SCAN_TEST: begin
            cmd      = OP_TEST;
            state_in = S_SCAN_RD;
         end
         S_CLAMP: begin
            cmd      = OP_CLAMP;
            state_in = S_RD_LO;
         end
         S_RD_LO: begin
            cmd      = OP_RD_LO;
            state_in = S_GET_LO;
         end
         S_GET_LO: begin
            cmd      = OP_GET_LO;
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            cmd      = OP_RD_HI;
            state_in = S_GET_HI;
         end
         S_GET_HI: begin
            cmd      = OP_GET_HI;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd      = OP_DIV_INIT;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            if (status.div_done) begin
               state_in = S_SAVE_W;
            end else begin
               cmd = OP_DIV_STEP;
            end
         end
         S_SAVE_W: begin
            cmd      = OP_SAVE_W;
            state_in = status.axis_y ? S_BASE : S_RD_FIRST;
         end
         S_BASE: begin
            cmd      = OP_BASE;
            state_in = S_GRD;
         end
         S_GRD: begin
            if (status.corners_done) begin
               state_in = S_FINISH;
            end else begin
               cmd      = OP_GRD;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd      = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd      = OP_ACC;
            state_in = S_GRD;
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd      = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> src/bilinear_offset_grid_add.sv
// top level of the bilinear offset grid adder
`timescale 1ns / 1ps

// req_ch takes load items (x node, y node, grid entry) and pixel items.
// a load is written in the cycle it is accepted and gives no result.
// a pixel item gives one item on rsp_ch: its value plus the offset
// interpolated from the four enclosing grid entries, saturated to 32 bits.
// csr_ch writes the node counts and is always ready; it is to be written only
// while idle, by the user: the block itself does not enforce this.
// each weight needs the 16-step divider unless it clips to 0 or 1.0; the
// enclosing nodes of each axis are found by a linear search through its node
// table, each node read followed by a compare.
// the next item can be accepted once the result is registered; a new pixel
// is not taken until the previous one is finished.
// a finished result waits in the output register while the next item is
// taken; if rsp_ch still stalls when the next result is ready, the block
// holds there. reset clears the handshake state and sets both counts to 2;
// the tables are not cleared and must be loaded before use.
module bilinear_offset_grid_add import bogadd_pkg::*; #(
   parameter int MAX_X_NODES = DEF_MAX_X_NODES,
   parameter int MAX_Y_NODES = DEF_MAX_Y_NODES
) (
   input  logic        clock,
   input  logic        reset,
   bogadd_req_if.sink  req_ch,
   bogadd_rsp_if.source rsp_ch,
   bogadd_csr_if.sink  csr_ch
);

   op_type     cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   bogadd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bogadd_dp #(
      .MAX_X_NODES (MAX_X_NODES),
      .MAX_Y_NODES (MAX_Y_NODES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_ch.action),
      .req_table_index     (req_ch.table_index),
      .req_data_word       (req_ch.data_word),
      .req_row_position    (req_ch.row_position),
      .req_column          (req_ch.column),
      .csr_valid           (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_corrected_value (rsp_ch.corrected_value),
      .rsp_saturated       (rsp_ch.saturated)
   );

`ifndef SYNTHESIS
   a_pixel_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ready && req_ch.action == ACT_PIXEL) |=> !req_ready)
      else $error("pixel item did not start processing");

   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ready && req_ch.action != ACT_PIXEL) |=> req_ready)
      else $error("load item stalled the input");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd == OP_FINISH))
      else $error("result raised without a finished pixel");
`endif

endmodule

>>> sim/testbench.sv
// testbench for the bilinear offset grid adder: loads, pixels, count writes and checks
`timescale 1ns / 1ps

module testbench;
   import bogadd_pkg::*;

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } pixel_result_type;

   logic clock;
   logic reset;

   bogadd_req_if req_ch ();
   bogadd_rsp_if rsp_ch ();
   bogadd_csr_if csr_ch ();

   bilinear_offset_grid_add i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // shadow state of the block
   logic [31:0] x_nodes [DEF_MAX_X_NODES];
   logic [31:0] y_nodes [DEF_MAX_Y_NODES];
   logic [31:0] offsets [GRID_DEPTH];
   logic [4:0]  x_count_reg;
   logic [4:0]  y_count_reg;

   pixel_result_type pending_pixels [$];
   int  mismatches;
   int  burst_left;
   int  items_sent;
   bit  hold_rsp;
   int  idle_cycles;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 200;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_count(logic [4:0] r, int depth);
      if (r < 2) return 2;
      if (r > depth) return depth;
      return r;
   endfunction

   // lower node index and upper node weight for one axis
   function automatic void locate_node(input bit y_axis, input int n, input logic [15:0] coord,
                                       output int lower, output logic [16:0] weight);
      logic [31:0] pos, first, last, lo, hi;
      logic [63:0] w;
      int idx;
      pos   = {8'd0, coord, 8'd0};
      first = y_axis ? y_nodes[0] : x_nodes[0];
      last  = y_axis ? y_nodes[n-1] : x_nodes[n-1];
      if (pos < first) pos = first;
      if (pos > last) pos = last;
      idx = n;
      for (int i = n - 1; i >= 0; i--) begin
         if ((y_axis ? y_nodes[i] : x_nodes[i]) > pos) idx = i;
      end
      if (idx < 1) idx = 1;
      if (idx > n - 1) idx = n - 1;
      lower = idx - 1;
      lo = y_axis ? y_nodes[idx-1] : x_nodes[idx-1];
      hi = y_axis ? y_nodes[idx] : x_nodes[idx];
      if (hi <= lo || pos < lo) begin
         weight = '0;
      end else begin
         w = {16'd0, pos - lo, 16'd0} / {32'd0, hi - lo};
         weight = (w > 64'h10000) ? ONE_Q16 : w[16:0];
      end
   endfunction

   function automatic void predict_item(action_type act, logic [7:0] idx, logic signed [31:0] word,
                                        logic [15:0] row, logic [15:0] col);
      int nx, ny, xl, yl;
      logic [16:0] wx, wy;
      longint g00, g01, g10, g11, top, bot, v;
      logic signed [64:0] biased;
      longint offset, sum;
      pixel_result_type r;
      case (act)
         ACT_LOAD_X: if (idx < DEF_MAX_X_NODES) x_nodes[idx] = word;
         ACT_LOAD_Y: if (idx < DEF_MAX_Y_NODES) y_nodes[idx] = word;
         ACT_LOAD_GRID: offsets[idx] = word;
         default: begin
            nx = eff_count(x_count_reg, DEF_MAX_X_NODES);
            ny = eff_count(y_count_reg, DEF_MAX_Y_NODES);
            locate_node(1'b0, nx, col, xl, wx);
            locate_node(1'b1, ny, row, yl, wy);
            g00 = $signed(offsets[yl*nx + xl]);
            g01 = $signed(offsets[yl*nx + xl + 1]);
            g10 = $signed(offsets[(yl+1)*nx + xl]);
            g11 = $signed(offsets[(yl+1)*nx + xl + 1]);
            top = g00 * (65536 - longint'(wx)) + g01 * longint'(wx);
            bot = g10 * (65536 - longint'(wx)) + g11 * longint'(wx);
            v = top * (65536 - longint'(wy)) + bot * longint'(wy);
            biased = 65'(v) + 65'sh80000000;
            offset = longint'(biased >>> 32);
            sum = longint'(word) + offset;
            r.sat = 0;
            if (sum > 64'sh7FFFFFFF) begin
               sum = 64'sh7FFFFFFF;
               r.sat = 1;
            end
            if (sum < -64'sh80000000) begin
               sum = -64'sh80000000;
               r.sat = 1;
            end
            r.value = sum[31:0];
            pending_pixels.push_back(r);
         end
      endcase
   endfunction

   // send one item, with bursts and random gaps
   task automatic send_item(action_type act, logic [7:0] idx, logic [31:0] word,
                            logic [15:0] row, logic [15:0] col);
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.table_index  <= idx;
      req_ch.data_word    <= word;
      req_ch.row_position <= row;
      req_ch.column       <= col;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      predict_item(act, idx, word, row, col);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_count(csr_index_type idx, logic [4:0] v);
      bit taken;
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v;
      do begin
         @(negedge clock);
         taken = csr_ch.ready;
         @(posedge clock);
      end while (!taken);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_X_COUNT) x_count_reg = v;
      else y_count_reg = v;
   endtask

   task automatic load_nodes(bit y_axis, bit sorted);
      logic [31:0] n;
      n = $urandom_range(0, 32'h40000);
      for (int i = 0; i < 16; i++) begin
         if (!sorted) n = $urandom();
         else if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 4);
         else n = n + $urandom_range(1, 32'h100000);
         send_item(y_axis ? ACT_LOAD_Y : ACT_LOAD_X, 8'(i), n, 16'($urandom()),
                   16'($urandom()));
      end
   endtask

   task automatic load_grid(int mode);
      logic [31:0] g;
      for (int i = 0; i < GRID_DEPTH; i++) begin
         case (mode)
            0: g = $urandom_range(0, 32'h60000) - 32'h30000;
            1: g = 32'h7FFFFFFF;
            2: g = 32'h80000000;
            default: g = $urandom();
         endcase
         send_item(ACT_LOAD_GRID, 8'(i), g, 16'($urandom()), 16'($urandom()));
      end
   endtask

   function automatic logic [15:0] pick_coord(bit y_axis);
      logic [31:0] n;
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom());
         default: begin
            n = y_axis ? y_nodes[$urandom_range(0, 15)] : x_nodes[$urandom_range(0, 15)];
            return 16'((n >> 8) + $urandom_range(0, 2) - 1);
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_pixel_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h200000) - 32'h100000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_pixel();
      send_item(ACT_PIXEL, 8'($urandom()), pick_pixel_value(), pick_coord(1'b1),
                pick_coord(1'b0));
   endtask

   task automatic test_extremes();
      load_nodes(1'b0, 1'b1);
      load_nodes(1'b1, 1'b1);
      load_grid(0);
      send_item(ACT_PIXEL, 8'd0, 32'h00000000, 16'h0000, 16'h0000);
      send_item(ACT_PIXEL, 8'hFF, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_PIXEL, 8'h55, 32'h80000000, 16'h0000, 16'hFFFF);
      send_item(ACT_PIXEL, 8'hAA, 32'h12345678, 16'hFFFF, 16'h0000);
      send_item(ACT_PIXEL, 8'h0F, $urandom(), 16'(x_nodes[1] >> 8), 16'(y_nodes[1] >> 8));
      // loads beyond the node tables are dropped
      send_item(ACT_LOAD_X, 8'd16, 32'h0, 16'h0, 16'h0);
      send_item(ACT_LOAD_Y, 8'd255, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 4; i++) send_pixel();
   endtask

   task automatic test_saturation();
      load_grid(1);
      send_item(ACT_PIXEL, 8'd0, 32'h7FFFFFFF, 16'd100, 16'd100);
      send_item(ACT_PIXEL, 8'd0, 32'h00000000, 16'hFFFF, 16'hFFFF);
      load_grid(2);
      send_item(ACT_PIXEL, 8'd0, 32'h80000000, 16'd100, 16'd100);
      send_item(ACT_PIXEL, 8'd0, 32'h7FFFFFFF, 16'd0, 16'd0);
      load_grid(3);
      for (int i = 0; i < 6; i++) send_pixel();
   endtask

   task automatic test_counts();
      logic [4:0] settings [8] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd31, 5'd9};
      for (int i = 0; i < 8; i++) begin
         write_count(CSR_X_COUNT, settings[i]);
         write_count(CSR_Y_COUNT, settings[7-i]);
         for (int k = 0; k < 6; k++) send_pixel();
      end
   endtask

   task automatic test_unordered_nodes();
      load_nodes(1'b0, 1'b0);
      load_nodes(1'b1, 1'b0);
      for (int i = 0; i < 20; i++) send_pixel();
      send_item(ACT_LOAD_X, 8'd3, x_nodes[2], 16'd0, 16'd0);
      send_item(ACT_LOAD_Y, 8'd5, y_nodes[4], 16'd0, 16'd0);
      for (int i = 0; i < 10; i++) send_pixel();
      load_nodes(1'b0, 1'b1);
      load_nodes(1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 12; i++) send_pixel();
      join
      wait_drained();
   endtask

   task automatic test_random(int goal);
      int start;
      int r;
      start = items_sent;
      while (items_sent - start < goal) begin
         if ($urandom_range(0, 299) == 0) begin
            write_count(CSR_X_COUNT, 5'($urandom_range(0, 31)));
            write_count(CSR_Y_COUNT, 5'($urandom_range(0, 31)));
         end
         r = $urandom_range(0, 99);
         if (r < 75) send_pixel();
         else if (r < 88) send_item(ACT_LOAD_GRID, 8'($urandom()), $urandom(),
                                    16'($urandom()), 16'($urandom()));
         else if (r < 93) send_item(action_type'($urandom_range(0, 1)), 8'($urandom()),
                                    $urandom(), 16'($urandom()), 16'($urandom()));
         else if (r < 95) load_nodes(1'($urandom_range(0, 1)), $urandom_range(0, 5) != 0);
         else send_item(action_type'($urandom_range(0, 1)), 8'($urandom_range(0, 15)),
                        $urandom_range(0, 32'hFFFFFF), 16'($urandom()), 16'($urandom()));
      end
   endtask

   // response stall pattern
   initial begin
      int mode;
      int phase_left;
      mode = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            mode = $urandom_range(0, 2);
            phase_left = $urandom_range(50, 400);
         end
         phase_left--;
         if (hold_rsp) rsp_ch.ready <= 1'b0;
         else if (mode == 0) rsp_ch.ready <= 1'b1;
         else if (mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         else rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      end
   end

   // result checker and idle watchdog
   always @(negedge clock) begin
      pixel_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: value %h sat %b", rsp_ch.corrected_value,
                        rsp_ch.saturated);
         end else begin
            exp_r = pending_pixels.pop_front();
            if (rsp_ch.corrected_value !== exp_r.value || rsp_ch.saturated !== exp_r.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h sat %b, got %h sat %b", exp_r.value,
                           exp_r.sat, rsp_ch.corrected_value, rsp_ch.saturated);
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL bilinear_offset_grid_add");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_LOAD_X;
      req_ch.table_index = '0;
      req_ch.data_word = '0;
      req_ch.row_position = '0;
      req_ch.column = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_X_COUNT;
      csr_ch.data = '0;
      x_count_reg = 5'd2;
      y_count_reg = 5'd2;
      mismatches = 0;
      burst_left = 0;
      items_sent = 0;
      hold_rsp = 0;
      idle_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_saturation();
      test_counts();
      test_unordered_nodes();
      test_backpressure();
      test_random(100);
      test_backpressure();
      wait_drained();
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("PASS bilinear_offset_grid_add");
      end else begin
         $display("FAIL bilinear_offset_grid_add");
      end
      $finish;
   end

endmodule
